/* design/pcrg_pkg.sv */
// ----------------------------------------------------------------------------
// pcrg_pkg
// Shared types and constants for the pinhole camera ray generator.
// ----------------------------------------------------------------------------
package pcrg_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int DIM_W      = 13;
  localparam int ONE_Q14    = 16384;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 15;
  localparam int DIV_W      = 47;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_DISTANCE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EYE_X          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EYE_Y          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EYE_Z          = 3'd5;

  typedef struct packed {
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;
    logic [7:0]  jitter_col;
    logic [7:0]  jitter_row;
  } pixel_req_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } ray_t;

  // magnitudes and signs of the direction, carried beside the sqrt
  typedef struct packed {
    logic [21:0] ax;
    logic [21:0] ay;
    logic [29:0] az;
    logic        neg_x;
    logic        neg_y;
    logic        zero;
  } comp_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } dir_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [15:0]      focal;
  } view_t;

endpackage

/* design/pcrg_front.sv */
// ----------------------------------------------------------------------------
// pcrg_front
// Forms the direction components, their squares and the squared length.
// Three register stages.
// ----------------------------------------------------------------------------
module pcrg_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  pcrg_pkg::pixel_req_t in_data,
  input  pcrg_pkg::view_t      view,
  output logic                 out_valid,
  output logic [63:0]          out_sum,
  output pcrg_pkg::comp_t      out_comp
);
  import pcrg_pkg::*;

  logic [DIM_W-1:0] w_c, h_c;
  logic [23:0]      x_pos, y_neg;

  // stage A
  logic             va;
  logic signed [23:0] xa, ya;
  logic [28:0]      fha;
  // stage B
  logic             vb;
  logic [21:0]      axb, ayb;
  logic [29:0]      azb;
  logic             nxb, nyb;
  logic [43:0]      sqxb, sqyb;
  logic [59:0]      sqzb;
  logic [21:0]      ax_n, ay_n;
  logic [29:0]      az_n;
  // stage C
  logic             vc;
  logic [61:0]      sum_n;

  always_comb begin
    w_c   = (view.width  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : view.width;
    h_c   = (view.height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : view.height;
    x_pos = {3'b0, in_data.pixel_col, 9'b0} + 24'd256 + {15'b0, in_data.jitter_col, 1'b0};
    y_neg = {3'b0, in_data.pixel_row, 9'b0} + 24'd256 + {15'b0, in_data.jitter_row, 1'b0};
    ax_n  = xa[23] ? 22'(-xa) : 22'(xa);
    ay_n  = ya[23] ? 22'(-ya) : 22'(ya);
    az_n  = {fha, 1'b0};
    sum_n = 62'(sqxb) + 62'(sqyb) + 62'(sqzb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
    end
    if (en) begin
      xa   <= $signed(x_pos - {3'b0, w_c, 8'b0});
      ya   <= $signed({3'b0, h_c, 8'b0} - y_neg);
      fha  <= view.focal * h_c;
      axb  <= ax_n;
      ayb  <= ay_n;
      azb  <= az_n;
      nxb  <= xa[23];
      nyb  <= ya[23];
      sqxb <= ax_n * ax_n;
      sqyb <= ay_n * ay_n;
      sqzb <= az_n * az_n;
      out_sum        <= {2'b0, sum_n};
      out_comp.ax    <= axb;
      out_comp.ay    <= ayb;
      out_comp.az    <= azb;
      out_comp.neg_x <= nxb;
      out_comp.neg_y <= nyb;
      out_comp.zero  <= (sum_n == 62'd0);
    end
  end

  assign out_valid = vc;

endmodule

/* design/pcrg_isqrt.sv */
// ----------------------------------------------------------------------------
// pcrg_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module pcrg_isqrt (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [63:0]     in_sum,
  input  pcrg_pkg::comp_t in_comp,
  output logic            out_valid,
  output logic [31:0]     out_root,
  output pcrg_pkg::comp_t out_comp
);
  import pcrg_pkg::*;

  logic        vld  [0:SQRT_STEPS];
  logic [34:0] rem  [0:SQRT_STEPS];
  logic [31:0] root [0:SQRT_STEPS];
  logic [63:0] sh   [0:SQRT_STEPS];
  comp_t       cmp  [0:SQRT_STEPS];

  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign sh[0]   = in_sum;
  assign cmp[0]  = in_comp;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    logic [34:0] rem2, trial;
    logic        take;
    always_comb begin
      rem2  = {rem[i][32:0], sh[i][63:62]};
      trial = {1'b0, root[i], 2'b01};
      take  = (rem2 >= trial);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        rem[i+1]  <= take ? (rem2 - trial) : rem2;
        root[i+1] <= {root[i][30:0], take};
        sh[i+1]   <= {sh[i][61:0], 2'b00};
        cmp[i+1]  <= cmp[i];
      end
    end
  end

  assign out_valid = vld[SQRT_STEPS];
  assign out_root  = root[SQRT_STEPS];
  assign out_comp  = cmp[SQRT_STEPS];

endmodule

/* design/pcrg_div.sv */
// ----------------------------------------------------------------------------
// pcrg_div
// Scales the three magnitudes by 16384/r with rounding, one quotient bit per
// stage in three lanes, then saturates and applies the signs.
// ----------------------------------------------------------------------------
module pcrg_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [31:0]     in_root,
  input  pcrg_pkg::comp_t in_comp,
  output logic            out_valid,
  output pcrg_pkg::dir_t  out_dir
);
  import pcrg_pkg::*;

  logic             vld [0:DIV_STEPS];
  logic [DIV_W-1:0] nx  [0:DIV_STEPS];
  logic [DIV_W-1:0] ny  [0:DIV_STEPS];
  logic [DIV_W-1:0] nz  [0:DIV_STEPS];
  logic [14:0]      qx  [0:DIV_STEPS];
  logic [14:0]      qy  [0:DIV_STEPS];
  logic [14:0]      qz  [0:DIV_STEPS];
  logic [31:0]      rr  [0:DIV_STEPS];
  comp_t            cmp [0:DIV_STEPS];

  logic             fv;
  logic [15:0]      sx, sy, sz;

  // rounding term r/2 folded into the dividend
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      nx[0]  <= DIV_W'({in_comp.ax, 14'b0}) + DIV_W'(in_root[31:1]);
      ny[0]  <= DIV_W'({in_comp.ay, 14'b0}) + DIV_W'(in_root[31:1]);
      nz[0]  <= DIV_W'({in_comp.az, 14'b0}) + DIV_W'(in_root[31:1]);
      qx[0]  <= '0;
      qy[0]  <= '0;
      qz[0]  <= '0;
      rr[0]  <= in_root;
      cmp[0] <= in_comp;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    localparam int K = DIV_STEPS - 1 - j;
    logic [DIV_W-1:0] d;
    logic             tx, ty, tz;
    always_comb begin
      d  = DIV_W'(rr[j]) << K;
      tx = (nx[j] >= d);
      ty = (ny[j] >= d);
      tz = (nz[j] >= d);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
      if (en) begin
        nx[j+1]  <= tx ? (nx[j] - d) : nx[j];
        ny[j+1]  <= ty ? (ny[j] - d) : ny[j];
        nz[j+1]  <= tz ? (nz[j] - d) : nz[j];
        qx[j+1]  <= {qx[j][13:0], tx};
        qy[j+1]  <= {qy[j][13:0], ty};
        qz[j+1]  <= {qz[j][13:0], tz};
        rr[j+1]  <= rr[j];
        cmp[j+1] <= cmp[j];
      end
    end
  end

  always_comb begin
    sx = (qx[DIV_STEPS] > 15'(ONE_Q14)) ? 16'(ONE_Q14) : {1'b0, qx[DIV_STEPS]};
    sy = (qy[DIV_STEPS] > 15'(ONE_Q14)) ? 16'(ONE_Q14) : {1'b0, qy[DIV_STEPS]};
    sz = (qz[DIV_STEPS] > 15'(ONE_Q14)) ? 16'(ONE_Q14) : {1'b0, qz[DIV_STEPS]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (en) begin
      fv <= vld[DIV_STEPS];
    end
    if (en) begin
      if (cmp[DIV_STEPS].zero) begin
        // degenerate direction: look straight ahead
        out_dir.dir_x <= '0;
        out_dir.dir_y <= '0;
        out_dir.dir_z <= -16'(ONE_Q14);
      end else begin
        out_dir.dir_x <= cmp[DIV_STEPS].neg_x ? -sx : sx;
        out_dir.dir_y <= cmp[DIV_STEPS].neg_y ? -sy : sy;
        out_dir.dir_z <= -sz;
      end
    end
  end

  assign out_valid = fv;

endmodule

/* design/pinhole_camera_ray_generator.sv */
// ----------------------------------------------------------------------------
// pinhole_camera_ray_generator
// Primary ray generation for a pinhole camera, one ray per pixel request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data) takes one pixel request per
//   cycle while in_stall is low: column, row and sub-pixel jitter. Output channel
//   (out_valid/out_stall/out_data) returns one ray per request, in order:
//   the eye position and a unit direction in signed Q2.14.
//   Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) sets image size,
//   focal distance and eye position; cfg_ready is always high. Write only
//   while no request is in flight.
//   The pipeline forms components and squares, then the square root (one
//   bit per stage), then the rounded scaling divide and output. Throughput is
//   one request per cycle unless stalled; the whole pipeline advances as one.
//   When the receiver stalls with a result waiting, every stage holds and
//   in_stall goes high in the same cycle.
//   Reset clears all valid bits and loads the register defaults
//   (640 x 480, focal 1.0, eye at the origin).
// ----------------------------------------------------------------------------
module pinhole_camera_ray_generator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pcrg_pkg::pixel_req_t                in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pcrg_pkg::ray_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pcrg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_data
);
  import pcrg_pkg::*;

  logic [DIM_W-1:0] image_width, image_height;
  logic [15:0]      focal_distance;
  logic [31:0]      eye_x, eye_y, eye_z;

  logic       en;
  view_t      view;
  logic       f_valid, s_valid, d_valid;
  logic [63:0] f_sum;
  comp_t      f_comp, s_comp;
  logic [31:0] s_root;
  dir_t       d_dir;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= DIM_W'(640);
      image_height   <= DIM_W'(480);
      focal_distance <= 16'd256;
      eye_x          <= '0;
      eye_y          <= '0;
      eye_z          <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:    image_width    <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT:   image_height   <= cfg_data[DIM_W-1:0];
        REG_FOCAL_DISTANCE: focal_distance <= cfg_data[15:0];
        REG_EYE_X:          eye_x          <= cfg_data;
        REG_EYE_Y:          eye_y          <= cfg_data;
        REG_EYE_Z:          eye_z          <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_comb begin
    view.width  = image_width;
    view.height = image_height;
    view.focal  = focal_distance;
  end

  pcrg_front u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(in_valid), .in_data(in_data), .view(view),
    .out_valid(f_valid), .out_sum(f_sum), .out_comp(f_comp)
  );

  pcrg_isqrt u_isqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(f_valid), .in_sum(f_sum), .in_comp(f_comp),
    .out_valid(s_valid), .out_root(s_root), .out_comp(s_comp)
  );

  pcrg_div u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_valid), .in_root(s_root), .in_comp(s_comp),
    .out_valid(d_valid), .out_dir(d_dir)
  );

  assign out_valid = d_valid;

  // origin is wired from the eye regs; change them only when idle (not enforced)
  always_comb begin
    out_data.origin_x = $signed(eye_x);
    out_data.origin_y = $signed(eye_y);
    out_data.origin_z = $signed(eye_z);
    out_data.dir_x    = d_dir.dir_x;
    out_data.dir_y    = d_dir.dir_y;
    out_data.dir_z    = d_dir.dir_z;
  end

  // dir_z is zero when focal distance or height is zero but x or y is not
  a_dir_z_neg: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.dir_z <= 16'sd0 && out_data.dir_z >= -16'sd16384))
    else $error("dir_z out of range");

  a_dir_x_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.dir_x >= -16'sd16384 && out_data.dir_x <= 16'sd16384))
    else $error("dir_x out of range");

  a_dir_y_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.dir_y >= -16'sd16384 && out_data.dir_y <= 16'sd16384))
    else $error("dir_y out of range");

endmodule
